// ===== src/tlwm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlwm_pkg
// Shared types and constants for the text line width measurement block.
// ----------------------------------------------------------------------------
package tlwm_pkg;

	localparam int WIDTH_BITS  = 24;
	localparam int STOP_BITS   = 16;
	localparam int ADDR_BITS   = 8;
	localparam int TABLE_DEPTH = 1 << ADDR_BITS;
	localparam int CNT_BITS    = $clog2(WIDTH_BITS);

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SEVEN   = 8'h37;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic [7:0] TAB_COUNT_RESET = 8'd8;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_MEASURE = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] code;
		logic [7:0] advance;
		logic       last;
	} tlwm_item_t;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] width;
		logic                  overflow;
	} tlwm_result_t;

	typedef struct packed {
		logic                  start;
		logic [WIDTH_BITS-1:0] dividend;
		logic [STOP_BITS-1:0]  divisor;
	} tlwm_rem_req_t;

	typedef struct packed {
		logic                 done;
		logic [STOP_BITS-1:0] rem;
	} tlwm_rem_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CARET,
		ST_CARET_ADD,
		ST_FETCH,
		ST_GLYPH,
		ST_STOP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_TAB_ADD,
		ST_DONE
	} tlwm_state_t;

endpackage

// ===== src/tlwm_rem.sv =====
// ----------------------------------------------------------------------------
// tlwm_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tlwm_rem
	import tlwm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  tlwm_rem_req_t req,
	output tlwm_rem_rsp_t rsp
);

	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WIDTH_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [STOP_BITS-1:0]  rem_q;
	logic [STOP_BITS-1:0]  divisor_q;
	logic [WIDTH_BITS-1:0] dvd_q;
	logic [STOP_BITS:0]    shifted;
	logic [STOP_BITS:0]    diff;
	logic [STOP_BITS-1:0]  rem_next;

	always_comb begin
		shifted = {rem_q, dvd_q[WIDTH_BITS-1]};
		diff    = shifted - {1'b0, divisor_q};
		if (shifted >= {1'b0, divisor_q}) begin
			rem_next = diff[STOP_BITS-1:0];
		end else begin
			rem_next = shifted[STOP_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[WIDTH_BITS-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== src/text_line_width_measure.sv =====
// ----------------------------------------------------------------------------
// text_line_width_measure
// Measures the widest line of a byte string against a glyph advance table.
//
//   Channel   Signals                           Moves
//   item      item_valid, item_ready, item      load or measure transaction
//   result    result_valid, result_ready, result widest line and overflow
//   config    cfg_we, cfg_wdata                 tab_count register write
//
// After reset all 256 table entries are cleared; item_ready stays low until
// then. A load is taken in idle. A newline or color code goes through fetch
// or caret and then done, a glyph through fetch, glyph and done, and a caret
// ended by a code other than 0 to 7 adds caret-add. A tab runs the 24-step
// remainder unit. A final character waits while the previous result is not taken.
// ----------------------------------------------------------------------------
module text_line_width_measure
	import tlwm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  tlwm_item_t   item,
	output logic         result_valid,
	input  logic         result_ready,
	output tlwm_result_t result,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	function automatic logic [WIDTH_BITS:0] sat_add(
		input logic [WIDTH_BITS-1:0] a,
		input logic [WIDTH_BITS-1:0] b
	);
		logic [WIDTH_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[WIDTH_BITS]) begin
			sat_add = {1'b1, {WIDTH_BITS{1'b1}}};
		end else begin
			sat_add = s;
		end
	endfunction

	tlwm_state_t state_q, state_next;

	logic [7:0]            mem [TABLE_DEPTH];
	logic [7:0]            rdata_q;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  rd_addr;
	logic [ADDR_BITS-1:0]  clr_cnt_q;

	logic [7:0]            tab_count_q;
	logic [7:0]            code_q;
	logic                  last_q;
	logic [WIDTH_BITS-1:0] line_width_q;
	logic [WIDTH_BITS-1:0] widest_q;
	logic                  caret_pending_q;
	logic                  sat_q;
	logic [STOP_BITS-1:0]  stop_q;

	logic                  result_valid_q;
	tlwm_result_t          result_q;

	logic                  item_acc;
	logic                  is_digit;
	logic                  out_free;
	logic [WIDTH_BITS-1:0] add_b;
	logic [WIDTH_BITS:0]   add_res;
	logic [WIDTH_BITS-1:0] closed;

	tlwm_rem_req_t rem_req;
	tlwm_rem_rsp_t rem_rsp;

	tlwm_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	assign item_acc = item_valid && item_ready;
	assign is_digit = (code_q >= CH_ZERO) && (code_q <= CH_SEVEN);
	assign out_free = !result_valid_q || result_ready;
	assign add_b    = (state_q == ST_TAB_ADD) ? WIDTH_BITS'(stop_q) : WIDTH_BITS'(rdata_q);
	assign add_res  = sat_add(line_width_q, add_b);
	assign closed   = (line_width_q > widest_q) ? line_width_q : widest_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ADDR_BITS'(TABLE_DEPTH - 1)) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_acc && item.func == FUNC_MEASURE) begin
					state_next = caret_pending_q ? ST_CARET : ST_FETCH;
				end
			end
			ST_CARET: begin
				state_next = is_digit ? ST_DONE : ST_CARET_ADD;
			end
			ST_CARET_ADD: begin
				state_next = ST_FETCH;
			end
			ST_FETCH: begin
				priority if (code_q == CH_CARET && !last_q) begin
					state_next = ST_DONE;
				end else if (code_q == CH_NEWLINE) begin
					state_next = ST_DONE;
				end else if (code_q == CH_TAB) begin
					state_next = ST_STOP;
				end else begin
					state_next = ST_GLYPH;
				end
			end
			ST_GLYPH: begin
				state_next = ST_DONE;
			end
			ST_STOP: begin
				state_next = ST_DIV_START;
			end
			ST_DIV_START: begin
				state_next = (stop_q == '0) ? ST_DONE : ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (rem_rsp.done) begin
					state_next = ST_TAB_ADD;
				end
			end
			ST_TAB_ADD: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (!last_q || out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready       = (state_q == ST_IDLE);
		rd_en            = 1'b0;
		rd_addr          = code_q;
		rem_req.start    = (state_q == ST_DIV_START) && (stop_q != '0);
		rem_req.dividend = line_width_q;
		rem_req.divisor  = stop_q;
		unique case (state_q)
			ST_CARET: begin
				rd_en   = !is_digit;
				rd_addr = CH_CARET;
			end
			ST_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = (code_q == CH_TAB) ? CH_SPACE : code_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_cnt_q] <= '0;
		end else if (item_acc && item.func == FUNC_LOAD) begin
			mem[item.code] <= item.advance;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_count_q <= TAB_COUNT_RESET;
		end else if (cfg_we) begin
			tab_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			code_q <= item.code;
			last_q <= item.last;
		end
		if (state_q == ST_STOP) begin
			stop_q <= {8'b0, rdata_q} * {8'b0, tab_count_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q    <= '0;
			widest_q        <= '0;
			caret_pending_q <= 1'b0;
			sat_q           <= 1'b0;
			result_valid_q  <= 1'b0;
			result_q        <= '0;
		end else begin
			if (state_q == ST_DONE && last_q && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CARET: begin
					caret_pending_q <= 1'b0;
				end
				ST_CARET_ADD, ST_GLYPH, ST_TAB_ADD: begin
					line_width_q <= add_res[WIDTH_BITS-1:0];
					sat_q        <= sat_q | add_res[WIDTH_BITS];
				end
				ST_FETCH: begin
					if (code_q == CH_CARET && !last_q) begin
						caret_pending_q <= 1'b1;
					end else if (code_q == CH_NEWLINE) begin
						widest_q     <= closed;
						line_width_q <= '0;
					end
				end
				ST_DIV_WAIT: begin
					if (rem_rsp.done) begin
						line_width_q <= line_width_q - WIDTH_BITS'(rem_rsp.rem);
					end
				end
				ST_DONE: begin
					if (last_q && out_free) begin
						result_q.width    <= closed;
						result_q.overflow <= sat_q;
						line_width_q      <= '0;
						widest_q          <= '0;
						caret_pending_q   <= 1'b0;
						sat_q             <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
